[hdl/cfr_plus_regret_matching_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef CFR_PLUS_REGRET_MATCHING_CORE_MACROS_SVH
`define CFR_PLUS_REGRET_MATCHING_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CFR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[hdl/cfr_pkg.sv]
// Package with shared widths, constants and types of the regret matching core.
package cfr_pkg;
   localparam int MaxActions = 16;
   localparam int MaxHands   = 2048;
   localparam int ActW       = $clog2(MaxActions);
   localparam int HandW      = $clog2(MaxHands);
   localparam int EntW       = ActW + HandW;
   localparam int Entries    = MaxActions * MaxHands;
   localparam int RegW       = 31;
   localparam int SumW       = 35;
   localparam int CumW       = 63;
   localparam int ProbW      = 17;
   localparam int QuoW       = 18;
   localparam int DivNumW    = 51;
   localparam logic [ProbW-1:0] ProbOne = 17'h10000;

   // Operation codes of the request stream.
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   // Register indexes on the configuration port.
   localparam logic [0:0] REG_ACTIONS = 1'b0;
   localparam logic [0:0] REG_HANDS   = 1'b1;

   // Request (start and operands) and response (done and quotient) of the shared divider.
   typedef struct packed {
      logic                start;
      logic [DivNumW-1:0]  numer;
      logic [SumW-1:0]     denom;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [QuoW-1:0]     quot;
   } div_rsp_type;
endpackage

[hdl/cfr_div.sv]
// Restoring divider, one quotient bit per cycle, saturating at the quotient width.
module cfr_div
   import cfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);
   localparam int CntW = $clog2(DivNumW + 1);

   logic [DivNumW-1:0] num_ff, num_in;
   logic [SumW:0]      rem_ff, rem_in;
   logic [SumW-1:0]    den_ff, den_in;
   logic [QuoW-1:0]    quo_ff, quo_in;
   logic               sat_ff, sat_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SumW+1:0]    trial;

   // A start loads the operands; while busy, one shift and subtract step per cycle.
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[DivNumW-1]} - {2'b00, den_ff};
      if (div_req.start) begin
         num_in  = div_req.numer;
         den_in  = div_req.denom;
         rem_in  = '0;
         quo_in  = '0;
         sat_in  = 1'b0;
         cnt_in  = CntW'(DivNumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[DivNumW-2:0], 1'b0};
         if (!trial[SumW+1]) begin
            rem_in = trial[SumW:0];
            sat_in = sat_ff | quo_ff[QuoW-1];
            quo_in = {quo_ff[QuoW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[SumW-1:0], num_ff[DivNumW-1]};
            sat_in = sat_ff | quo_ff[QuoW-1];
            quo_in = {quo_ff[QuoW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = sat_ff ? '1 : quo_ff;
endmodule

[hdl/cfr_plus_regret_matching_core.sv]
// Top level of the CFR+ regret matching core: tables, sequencer and ports.
//  channel | dir | handshake          | payload
//  req     | in  | tvalid/tready      | tdata: op, action, hand, regret, iteration
//  rsp     | out | tvalid/tready      | tdata: positive, cumulative, probability
//  csr     | in  | APB psel/penable   | action_count at 0x0, hand_count at 0x4
// After reset one clearing pass zeroes the 32768 entries of both tables and the 2048 hand
// sums together, one address a cycle, and req_tready first rises when the pass ends.
// An update goes from its beat to the result through read, clip, sum, two 31x10 multiply
// steps, accumulate, write and output. A read waits on the 51 steps of the shared divider,
// which also forms the uniform probability; an out-of-range entry goes from read to output.
// The result sits in an output register; the next request waits until it is taken.
module cfr_plus_regret_matching_core
   import cfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // bit 0 opcode, 4:1 action_index, 15:5 hand_index, 47:16 regret_value,
   // 67:48 iteration, zero fill to 72
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // 30:0 positive_regret, 93:31 cumulative_regret, 110:94 probability, fill to 112
   output logic [111:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_RDW = 4'd3,
      S_ADD = 4'd4, S_MLO = 4'd5, S_MHI = 4'd6, S_ACC = 4'd7, S_WR = 4'd8,
      S_DIV = 4'd9, S_OUT = 4'd10;

   logic [3:0]  state_ff, state_in;
   logic [4:0]  acts_ff;
   logic [11:0] hands_ff;
   logic [EntW-1:0] clr_ff;

   // Latched request fields.
   logic             op_ff;
   logic [ActW-1:0]  act_ff;
   logic [HandW-1:0] hand_ff;
   logic signed [31:0] rv_ff;
   logic [19:0]      it_ff;
   logic             oob_ff;

   // Memories with registered reads.
   logic [RegW-1:0] reg_mem [Entries];
   logic [CumW-1:0] cum_mem [Entries];
   logic [SumW-1:0] sum_mem [MaxHands];
   logic [RegW-1:0] reg_rd_ff;
   logic [CumW-1:0] cum_rd_ff;
   logic [SumW-1:0] sum_rd_ff;

   logic [RegW-1:0] clip_ff;
   logic [SumW-1:0] nsum_ff;
   logic [50:0]     prod_ff;
   logic [CumW-1:0] ncum_ff;
   logic [ProbW-1:0] prob_ff;
   logic            rsp_v_ff;
   logic [RegW-1:0] o_pos_ff;
   logic [CumW-1:0] o_cum_ff;
   logic [ProbW-1:0] o_prob_ff;

   logic [4:0]  eff_a;
   logic [12:0] eff_h;
   logic [EntW-1:0] ent;
   logic        wr_en;
   logic        clr_wr;
   logic [33:0] nv_wide;
   logic [35:0] sum_wide;
   logic [63:0] cum_wide;
   logic [40:0] mul_part;
   logic        req_acc;
   logic        cfg_wr;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign eff_a = (acts_ff == 5'd0) ? 5'd1 :
                  (acts_ff > 5'(MaxActions)) ? 5'(MaxActions) : acts_ff;
   assign eff_h = (hands_ff == 12'd0) ? 13'd1 :
                  ({1'b0, hands_ff} > 13'(MaxHands)) ? 13'(MaxHands) : {1'b0, hands_ff};
   assign ent   = {act_ff, hand_ff};
   assign req_tready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HANDS) ? {20'd0, hands_ff} : {27'd0, acts_ff};

   assign clr_wr = (state_ff == S_CLR);
   assign wr_en  = (state_ff == S_WR);

   // Regret, hand sum and cumulative adds; when registered the regret clips at zero and all saturate at the top.
   assign nv_wide  = {3'b000, reg_rd_ff} + {{2{rv_ff[31]}}, rv_ff};
   assign sum_wide = (act_ff == '0 ? 36'd0 : {1'b0, sum_rd_ff}) + {5'd0, clip_ff};
   assign cum_wide = {1'b0, cum_rd_ff} + {13'd0, prod_ff};
   // Shared 31x10 multiplier step, low then high half of the iteration.
   assign mul_part = {10'd0, clip_ff} * ((state_ff == S_MLO) ? {31'd0, it_ff[9:0]}
                                                              : {31'd0, it_ff[19:10]});

   // The divider forms regret / sum, or one over the actions in use when the sum is zero.
   assign div_req.start = (state_ff == S_RDW) && op_ff;
   assign div_req.numer = (sum_rd_ff == '0) ? {34'd0, ProbOne} : {4'd0, reg_rd_ff, 16'd0};
   assign div_req.denom = (sum_rd_ff == '0) ? {30'd0, eff_a} : sum_rd_ff;

   cfr_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR:  if (clr_ff == '1) state_in = S_IDLE;
         S_IDLE: if (req_acc) state_in = S_RD;
         S_RD:   state_in = oob_ff ? S_OUT : S_RDW;
         S_RDW:  state_in = !op_ff ? S_ADD : S_DIV;
         S_ADD:  state_in = S_MLO;
         S_MLO:  state_in = S_MHI;
         S_MHI:  state_in = S_ACC;
         S_ACC:  state_in = S_WR;
         S_WR:   state_in = S_OUT;
         S_DIV:  if (div_rsp.done) state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         acts_ff  <= 5'd2;
         hands_ff <= 12'd1326;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clr_wr) clr_ff <= clr_ff + 1'b1;
         if (cfg_wr && csr_paddr[2] == REG_ACTIONS) acts_ff  <= csr_pwdata[4:0];
         if (cfg_wr && csr_paddr[2] == REG_HANDS)   hands_ff <= csr_pwdata[11:0];
         if (state_ff == S_OUT) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
      end
   end

   // Memory ports: one write and one registered read per table.
   always_ff @(posedge clock) begin
      if (clr_wr) begin
         reg_mem[clr_ff] <= '0;
         cum_mem[clr_ff] <= '0;
         sum_mem[clr_ff[HandW-1:0]] <= '0;
      end else if (wr_en) begin
         reg_mem[ent] <= clip_ff;
         cum_mem[ent] <= ncum_ff;
         sum_mem[hand_ff] <= nsum_ff;
      end
      reg_rd_ff <= reg_mem[ent];
      cum_rd_ff <= cum_mem[ent];
      sum_rd_ff <= sum_mem[hand_ff];
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff   <= req_tdata[0];
         act_ff  <= req_tdata[4:1];
         hand_ff <= req_tdata[15:5];
         rv_ff   <= req_tdata[47:16];
         it_ff   <= req_tdata[67:48];
         oob_ff  <= ({1'b0, req_tdata[4:1]} >= eff_a) || ({2'b0, req_tdata[15:5]} >= eff_h);
      end
      case (state_ff)
         S_RDW: begin
            prob_ff <= '0;
            clip_ff <= nv_wide[33] ? '0 : (nv_wide[32:31] != 2'b00) ? '1 : nv_wide[30:0];
         end
         S_ADD: nsum_ff <= sum_wide[35] ? '1 : sum_wide[34:0];
         S_MLO: prod_ff <= {10'd0, mul_part};
         S_MHI: prod_ff <= prod_ff + {mul_part, 10'd0};
         S_ACC: ncum_ff <= cum_wide[63] ? '1 : cum_wide[62:0];
         S_DIV: prob_ff <= (div_rsp.quot > 18'(ProbOne)) ? ProbOne : div_rsp.quot[16:0];
         S_OUT: begin
            o_pos_ff  <= oob_ff ? '0 : (op_ff ? reg_rd_ff : clip_ff);
            o_cum_ff  <= oob_ff ? '0 : (op_ff ? cum_rd_ff : ncum_ff);
            o_prob_ff <= (oob_ff || !op_ff) ? '0 : prob_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {1'b0, o_prob_ff, o_cum_ff, o_pos_ff};
endmodule

[hdl/cfr_chk.sv]
// Port checker for the regret matching core, bound to the top level.
`include "cfr_plus_regret_matching_core_macros.svh"
module cfr_chk (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [111:0] rsp_tdata
);
   // The result valid holds until the beat is taken.
   `CFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // No request is taken while a result waits.
   `CFR_ASSERT_IMP(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   // After a request the core is busy the next cycle.
   `CFR_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   // Probability never exceeds one.
   `CFR_ASSERT_IMP(a_prob, clock, reset, rsp_tvalid, rsp_tdata[110:94] <= 17'h10000)
endmodule

bind cfr_plus_regret_matching_core cfr_chk u_chk (.*);

[tb/cfr_plus_regret_matching_core_tb.sv]
// Self-checking testbench of the CFR+ regret matching core.
`timescale 1ns / 100ps

module cfr_plus_regret_matching_core_tb
   import cfr_pkg::*;
();

   typedef struct packed {
      logic [RegW-1:0]  positive;
      logic [CumW-1:0]  cumulative;
      logic [ProbW-1:0] prob;
   } outcome_type;

   typedef struct packed {
      logic        op;
      logic [3:0]  act;
      logic [10:0] hand;
      logic [31:0] regret;
      logic [19:0] iter;
      logic        typed;
      outcome_type want;
   } dir_row_type;

   localparam logic [63:0] CumMax = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SumMax = 64'h7_FFFF_FFFF;
   localparam logic [63:0] RegMax = 64'h7FFF_FFFF;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Model state of the tables and registers.
   logic [RegW-1:0] regret_mem [Entries];
   logic [CumW-1:0] cum_mem    [Entries];
   logic [SumW-1:0] hand_sum   [MaxHands];
   logic [4:0]      actions_reg;
   logic [11:0]     hands_reg;

   outcome_type outcome_q[$];
   int       fail_count;
   int       send_gap_pct;
   int       take_stall_pct;

   // Directed rows, taken with the register values after reset.
   dir_row_type dir_rows [16] = '{
      '{OP_READ,   4'd0, 11'd0,    32'h0,        20'h0,     1'b1, '{31'd0, 63'd0, 17'd32768}},
      '{OP_UPDATE, 4'd0, 11'd0,    32'h7FFFFFFF, 20'hFFFFF, 1'b0, '{31'd0, 63'd0, 17'd0}},
      '{OP_UPDATE, 4'd1, 11'd0,    32'h80000000, 20'h0,     1'b1, '{31'd0, 63'd0, 17'd0}},
      '{OP_READ,   4'd0, 11'd0,    32'h0,        20'h0,     1'b0, '{31'd0, 63'd0, 17'd0}},
      '{OP_READ,   4'd1, 11'd0,    32'hFFFFFFFF, 20'hFFFFF, 1'b0, '{31'd0, 63'd0, 17'd0}},
      '{OP_UPDATE, 4'd2, 11'd0,    32'h12345678, 20'h3,     1'b1, '{31'd0, 63'd0, 17'd0}},
      '{OP_UPDATE, 4'd0, 11'd1326, 32'h12345678, 20'h3,     1'b1, '{31'd0, 63'd0, 17'd0}},
      '{OP_READ,   4'd15, 11'd2047, 32'h0,       20'h0,     1'b1, '{31'd0, 63'd0, 17'd0}},
      '{OP_UPDATE, 4'd0, 11'd1325, 32'h7FFFFFFF, 20'h1,     1'b0, '{31'd0, 63'd0, 17'd0}},
      '{OP_UPDATE, 4'd0, 11'd1325, 32'h7FFFFFFF, 20'h1,     1'b0, '{31'd0, 63'd0, 17'd0}},
      '{OP_UPDATE, 4'd1, 11'd7,    32'h40000000, 20'h5,     1'b0, '{31'd0, 63'd0, 17'd0}},
      '{OP_UPDATE, 4'd0, 11'd7,    32'h00000100, 20'h2,     1'b0, '{31'd0, 63'd0, 17'd0}},
      '{OP_READ,   4'd1, 11'd7,    32'h0,        20'h0,     1'b1,
        '{31'h40000000, 63'h140000000, 17'd65536}},
      '{OP_READ,   4'd1, 11'd1325, 32'h0,        20'h0,     1'b0, '{31'd0, 63'd0, 17'd0}},
      '{OP_UPDATE, 4'd0, 11'd3,    32'hFFFFFFFB, 20'hFFFFF, 1'b1, '{31'd0, 63'd0, 17'd0}},
      '{OP_READ,   4'd0, 11'd3,    32'h0,        20'h0,     1'b1, '{31'd0, 63'd0, 17'd32768}}
   };

   cfr_plus_regret_matching_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int used_actions();
      if (actions_reg == 0) return 1;
      if (actions_reg > MaxActions) return MaxActions;
      return actions_reg;
   endfunction

   function automatic int used_hands();
      if (hands_reg == 0) return 1;
      if (hands_reg > MaxHands) return MaxHands;
      return hands_reg;
   endfunction

   // Applies one request to the model tables and returns the beat it should produce.
   function automatic outcome_type regret_match(input logic op, input logic [3:0] act,
                                                input logic [10:0] hand,
                                                input logic [31:0] regret,
                                                input logic [19:0] iter);
      outcome_type     res;
      int              idx;
      longint          nv;
      logic [63:0]     clipped;
      logic [63:0]     sum;
      logic [63:0]     prod;
      logic [63:0]     cum;
      logic [63:0]     quo;
      res = '0;
      if (act >= used_actions() || hand >= used_hands()) return res;
      idx = act * MaxHands + hand;
      if (op == OP_UPDATE) begin
         nv = longint'(regret_mem[idx]) + longint'($signed(regret));
         if (nv < 0) nv = 0;
         if (nv > longint'(RegMax)) nv = longint'(RegMax);
         clipped = 64'(nv);
         regret_mem[idx] = clipped[RegW-1:0];
         sum = (act == 0) ? 64'd0 : 64'(hand_sum[hand]);
         sum = sum + clipped;
         if (sum > SumMax) sum = SumMax;
         hand_sum[hand] = sum[SumW-1:0];
         prod = clipped * 64'(iter);
         cum = 64'(cum_mem[idx]);
         if (prod > CumMax - cum) cum = CumMax;
         else cum = cum + prod;
         cum_mem[idx] = cum[CumW-1:0];
         res.positive = clipped[RegW-1:0];
         res.cumulative = cum[CumW-1:0];
      end else begin
         sum = 64'(hand_sum[hand]);
         if (sum == 0) quo = 64'd65536 / 64'(used_actions());
         else begin
            quo = (64'(regret_mem[idx]) << 16) / sum;
            if (quo > 64'd65536) quo = 64'd65536;
         end
         res.positive = regret_mem[idx];
         res.cumulative = cum_mem[idx];
         res.prob = quo[ProbW-1:0];
      end
      return res;
   endfunction

   // Sends one request beat; called at a falling edge and returns at one.
   task automatic send_req(input logic op, input logic [3:0] act, input logic [10:0] hand,
                           input logic [31:0] regret, input logic [19:0] iter,
                           input logic typed, input outcome_type want);
      outcome_type calc;
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, iter, regret, hand, act, op};
      do @(posedge clock); while (!req_tready);
      calc = regret_match(op, act, hand, regret, iter);
      if (typed) calc = want;
      outcome_q = {outcome_q, calc};
      @(negedge clock);
   endtask

   task automatic send_rand(input logic op, input int act, input int hand);
      logic [31:0] regret;
      case ($urandom_range(0, 5))
         0: regret = 32'h7FFFFFFF;
         1: regret = 32'h80000000;
         2, 3: regret = $urandom;
         default: regret = 32'($signed(21'($urandom)));
      endcase
      send_req(op, 4'(act), 11'(hand), regret, 20'($urandom), 1'b0, '0);
   endtask

   // Waits for every outstanding beat, then writes one register with an APB setup and access phase.
   task automatic write_reg(input logic [0:0] reg_idx, input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_idx == REG_ACTIONS) actions_reg = value[4:0];
      else hands_reg = value[11:0];
   endtask

   // The receiver stalls at random.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= take_stall_pct);
   end

   // Each result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.positive = rsp_tdata[30:0];
         got.cumulative = rsp_tdata[93:31];
         got.prob = rsp_tdata[110:94];
         if (outcome_q.size() == 0) begin
            $error("result beat with nothing expected");
            fail_count++;
         end else begin
            want = outcome_q.pop_front();
            if (got.positive !== want.positive) begin
               $error("positive_regret expected %0h actual %0h", want.positive, got.positive);
               fail_count++;
            end
            if (got.cumulative !== want.cumulative) begin
               $error("cumulative_regret expected %0h actual %0h",
                      want.cumulative, got.cumulative);
               fail_count++;
            end
            if (got.prob !== want.prob) begin
               $error("probability expected %0d actual %0d", want.prob, got.prob);
               fail_count++;
            end
         end
      end
   end

   initial begin
      int phase_act [4];
      int phase_hands [4];
      int phase_gap [4];
      int phase_stall [4];
      int phase_items [4];
      int sent;
      int acts;
      int hands;
      int hand;
      phase_act = '{31, 3, 0, 7};
      phase_hands = '{4095, 5, 0, 2048};
      phase_gap = '{30, 69, 0, 0};
      phase_stall = '{69, 30, 0, 0};
      phase_items = '{150, 150, 50, 100};
      fail_count = 0;
      send_gap_pct = 30;
      take_stall_pct = 69;
      actions_reg = 5'd2;
      hands_reg = 12'd1326;
      for (int i = 0; i < Entries; i++) begin
         regret_mem[i] = '0;
         cum_mem[i] = '0;
      end
      for (int i = 0; i < MaxHands; i++) hand_sum[i] = '0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows at the reset register values.
      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].op, dir_rows[i].act, dir_rows[i].hand, dir_rows[i].regret,
                  dir_rows[i].iter, dir_rows[i].typed, dir_rows[i].want);
      end

      // Random phases, mostly action-major update runs followed by reads.
      for (int p = 0; p < 4; p++) begin
         write_reg(REG_ACTIONS, 32'(phase_act[p]));
         write_reg(REG_HANDS, 32'(phase_hands[p]));
         send_gap_pct = phase_gap[p];
         take_stall_pct = phase_stall[p];
         acts = used_actions();
         hands = used_hands();
         sent = 0;
         while (sent < phase_items[p]) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: begin
                  hand = $urandom_range(0, hands - 1);
                  for (int a = 0; a < acts && sent < phase_items[p]; a++) begin
                     send_rand(OP_UPDATE, a, hand);
                     sent++;
                  end
                  for (int k = $urandom_range(0, 2); k > 0; k--) begin
                     send_rand(OP_READ, $urandom_range(0, acts - 1), hand);
                     sent++;
                  end
               end
               7, 8: begin
                  send_rand(OP_READ, $urandom_range(0, acts - 1),
                            $urandom_range(0, hands - 1));
                  sent++;
               end
               default: begin
                  send_rand(1'($urandom), $urandom_range(0, 15), $urandom_range(0, 2047));
                  sent++;
               end
            endcase
         end
      end

      // Drain the outstanding results.
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
